/* rtl/core/ryf_pkg.sv */
`timescale 1ns / 1ps

package ryf_pkg;

  // Field and register widths
  localparam int unsigned COMP_W        = 8;
  localparam int unsigned CFG_W         = 13;
  localparam int unsigned LINE_WIDTH_RST = 512;

  // Defaults for the top level parameters
  localparam int unsigned MAX_LINE_WIDTH_DEF = 4096;
  localparam int unsigned QUEUE_DEPTH_DEF    = 2;

  // BT.601 studio range matrix, 8-bit fixed point
  localparam logic [15:0] Y_R  = 16'd66;
  localparam logic [15:0] Y_G  = 16'd129;
  localparam logic [15:0] Y_B  = 16'd25;
  localparam logic [15:0] U_R  = 16'd38;
  localparam logic [15:0] U_G  = 16'd74;
  localparam logic [15:0] U_B  = 16'd112;
  localparam logic [15:0] V_R  = 16'd112;
  localparam logic [15:0] V_G  = 16'd94;
  localparam logic [15:0] V_B  = 16'd18;
  localparam logic [15:0] RND  = 16'd128;
  localparam logic [15:0] C_OFS = 16'd32896; // rounding plus 128 << 8
  localparam logic [7:0]  Y_OFS = 8'd16;
  localparam logic [7:0]  C_MID = 8'd128;

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } ryf_pixel_t;

  typedef struct packed {
    logic [COMP_W-1:0] luma_even;
    logic [COMP_W-1:0] chroma_blue;
    logic [COMP_W-1:0] luma_odd;
    logic [COMP_W-1:0] chroma_red;
    logic              line_end;
  } ryf_yuyv_t;

  // One converted pixel, classified by position in its pair
  typedef struct packed {
    logic [COMP_W-1:0] luma;
    logic [COMP_W-1:0] cb;
    logic [COMP_W-1:0] cr;
    logic              odd;
    logic              last;
  } ryf_entry_t;

endpackage

/* rtl/core/ryf_fifo.sv */
`timescale 1ns / 1ps

module ryf_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNTW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store incoming words
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNTW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNTW'(1);
      end
    end
  end

endmodule

/* rtl/core/ryf_front.sv */
`timescale 1ns / 1ps

module ryf_front #(
  parameter int unsigned MAX_LINE_WIDTH = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic [ryf_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       pix_valid,
  input  ryf_pkg::ryf_pixel_t        pix,
  output logic                       push_valid,
  input  logic                       push_ready,
  output ryf_pkg::ryf_entry_t        push_entry
);

  import ryf_pkg::*;

  localparam int unsigned CW     = $clog2(MAX_LINE_WIDTH);
  localparam int unsigned EW     = $clog2(MAX_LINE_WIDTH + 1);
  localparam int unsigned CMPW   = (CW + 1 > EW) ? CW + 1 : EW;
  localparam int unsigned LW     = (CFG_W > EW) ? CFG_W : EW;
  localparam int unsigned MAX_EVEN = ((MAX_LINE_WIDTH / 2) * 2 < 2) ? 2
                                   : (MAX_LINE_WIDTH / 2) * 2;
  localparam int unsigned EFF_RST = (LINE_WIDTH_RST > MAX_EVEN) ? MAX_EVEN
                                  : LINE_WIDTH_RST;

  logic [CW-1:0]  column;
  logic [EW-1:0]  eff_width;
  logic [LW-1:0]  cfg_even;
  logic [LW-1:0]  eff_width_next;
  logic           last;
  logic           accept;
  logic [15:0]    r16, g16, b16;
  logic [15:0]    y_sum, u_sum, v_sum;

  // Clamp the written width to an even value in range
  always_comb begin
    cfg_even = LW'({cfg_data[CFG_W-1:1], 1'b0});
    if (cfg_even > LW'(MAX_EVEN)) begin
      eff_width_next = LW'(MAX_EVEN);
    end else if (cfg_even < LW'(2)) begin
      eff_width_next = LW'(2);
    end else begin
      eff_width_next = cfg_even;
    end
  end

  // Convert the pixel
  always_comb begin
    r16   = 16'(pix.red);
    g16   = 16'(pix.green);
    b16   = 16'(pix.blue);
    y_sum = Y_R * r16 + Y_G * g16 + Y_B * b16 + RND;
    u_sum = U_B * b16 + C_OFS - U_R * r16 - U_G * g16;
    v_sum = V_R * r16 + C_OFS - V_G * g16 - V_B * b16;
  end

  assign last       = (CMPW'(column) + CMPW'(1)) >= CMPW'(eff_width);
  assign push_valid = pix_valid;
  assign accept     = pix_valid && push_ready;

  // Tag the converted pixel with its pair position
  always_comb begin
    push_entry.luma = y_sum[15:8] + Y_OFS;
    push_entry.cb   = u_sum[15:8];
    push_entry.cr   = v_sum[15:8];
    push_entry.odd  = column[0];
    push_entry.last = column[0] && last;
  end

  // Hold the width, advance the column
  always_ff @(posedge clk) begin
    if (rst) begin
      eff_width <= EW'(EFF_RST);
      column    <= '0;
    end else begin
      if (cfg_valid) begin
        eff_width <= EW'(eff_width_next);
      end
      if (accept) begin
        if (column[0] && last) begin
          column <= '0;
        end else begin
          column <= column + CW'(1);
        end
      end
    end
  end

endmodule

/* rtl/core/ryf_back.sv */
`timescale 1ns / 1ps

module ryf_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  ryf_pkg::ryf_entry_t  pop_entry,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ryf_pkg::ryf_yuyv_t   out_word
);

  import ryf_pkg::*;

  logic [COMP_W-1:0] held_luma;
  logic [COMP_W-1:0] held_u;
  logic [COMP_W-1:0] held_v;
  logic [COMP_W-1:0] left_u;
  logic [COMP_W-1:0] left_v;
  logic [9:0]        sum_u;
  logic [9:0]        sum_v;
  logic              take;
  logic              take_odd;

  // An even word only loads the hold registers; an odd one needs a free output slot
  assign pop_ready = !pop_entry.odd || !out_valid || !out_stall;
  assign take      = pop_valid && pop_ready;
  assign take_odd  = take && pop_entry.odd;

  // Chroma filter [1 2 1] / 4 with rounding
  always_comb begin
    sum_u = 10'(left_u) + {1'b0, held_u, 1'b0} + 10'(pop_entry.cb) + 10'd2;
    sum_v = 10'(left_v) + {1'b0, held_v, 1'b0} + 10'(pop_entry.cr) + 10'd2;
  end

  // Hold the even pixel and the left neighbor, drive the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      held_luma <= '0;
      held_u    <= C_MID;
      held_v    <= C_MID;
      left_u    <= C_MID;
      left_v    <= C_MID;
    end else begin
      if (take_odd) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (take && !pop_entry.odd) begin
        held_luma <= pop_entry.luma;
        held_u    <= pop_entry.cb;
        held_v    <= pop_entry.cr;
      end
      if (take_odd) begin
        left_u <= pop_entry.last ? C_MID : pop_entry.cb;
        left_v <= pop_entry.last ? C_MID : pop_entry.cr;
      end
    end
  end

  // Load the output word
  always_ff @(posedge clk) begin
    if (take_odd) begin
      out_word.luma_even   <= held_luma;
      out_word.chroma_blue <= sum_u[9:2];
      out_word.luma_odd    <= pop_entry.luma;
      out_word.chroma_red  <= sum_v[9:2];
      out_word.line_end    <= pop_entry.last;
    end
  end

endmodule

/* rtl/core/rgb_to_yuyv_filtered_chroma_core.sv */
`timescale 1ns / 1ps
// An odd pixel is registered in the queue, then in the output word. Throughput: one pixel
// per cycle while in_stall is low, one word every two pixels; the two-entry queue between
// the converter and the pair assembler lets either side stall without a bubble.
// Reset (rst, synchronous, active high): queue and output empty, column 0, width 512,
// held and left chroma 128.
module rgb_to_yuyv_filtered_chroma_core #(
  parameter int unsigned MAX_LINE_WIDTH = ryf_pkg::MAX_LINE_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH    = ryf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [ryf_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  ryf_pkg::ryf_pixel_t       in_word,
  output logic                      out_valid,
  input  logic                      out_stall,
  output ryf_pkg::ryf_yuyv_t        out_word
);

  import ryf_pkg::*;

  localparam int unsigned EWID = $bits(ryf_entry_t);

  logic             push_valid;
  logic             push_ready;
  ryf_entry_t       push_entry;
  logic             pop_valid;
  logic             pop_ready;
  logic [EWID-1:0]  pop_bits;
  ryf_entry_t       pop_entry;

  assign cfg_ready = 1'b1;
  assign in_stall  = !push_ready;
  assign pop_entry = ryf_entry_t'(pop_bits);

  ryf_front #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .pix_valid  (in_valid),
    .pix        (in_word),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  ryf_fifo #(
    .WIDTH (EWID),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (EWID'(push_entry)),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_bits)
  );

  ryf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

/* rtl/core/ryf_checker.sv */
`timescale 1ns / 1ps

module ryf_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input ryf_pkg::ryf_yuyv_t out_word
);

  import ryf_pkg::*;

  // Reset empties the output and the queue
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output or stall not clear after reset");

  // A stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  // Luma stays in studio range
  a_luma_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.luma_even >= 8'd16 && out_word.luma_even <= 8'd235 &&
                  out_word.luma_odd >= 8'd16 && out_word.luma_odd <= 8'd235)
    else $error("luma out of range");

  // Filtered chroma stays in studio range
  a_chroma_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.chroma_blue >= 8'd16 && out_word.chroma_blue <= 8'd240 &&
                  out_word.chroma_red >= 8'd16 && out_word.chroma_red <= 8'd240)
    else $error("chroma out of range");

endmodule

bind rgb_to_yuyv_filtered_chroma_core ryf_checker u_ryf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

/* tb/sv/tb_rgb_to_yuyv_filtered_chroma_core.sv */
`timescale 1ns / 1ps

module tb_rgb_to_yuyv_filtered_chroma_core;
  import ryf_pkg::*;

  typedef struct {
    ryf_pixel_t pix;
    bit         typed;
    ryf_yuyv_t  word;
  } pixel_row_t;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_data;
  logic               in_valid;
  logic               in_stall;
  ryf_pixel_t         in_word;
  logic               out_valid;
  logic               out_stall;
  ryf_yuyv_t          out_word;

  // Words still owed by the block, oldest first
  ryf_yuyv_t expected_words[$];
  int        mismatches = 0;

  // Shaping of the two sides
  bit calm = 1'b0;
  int hold_request = 0;
  int hold_left = 0;

  // Converter state mirrored from the block
  logic [CFG_W-1:0] width_reg;
  int unsigned      col_count;
  logic [7:0]       held_y;
  logic [7:0]       held_cb;
  logic [7:0]       held_cr;
  logic [7:0]       left_cb;
  logic [7:0]       left_cr;

  // Directed pixels, first column 0 after reset with width 512
  pixel_row_t directed_rows [20] = '{
    '{24'h000000, 1'b0, '0},
    '{24'h000000, 1'b1, {8'd16, 8'd128, 8'd16, 8'd128, 1'b0}},
    '{24'hFFFFFF, 1'b0, '0},
    '{24'hFFFFFF, 1'b1, {8'd235, 8'd128, 8'd235, 8'd128, 1'b0}},
    '{24'hFF0000, 1'b0, '0},
    '{24'hFF0000, 1'b0, '0},
    '{24'h00FF00, 1'b0, '0},
    '{24'h00FF00, 1'b0, '0},
    '{24'h0000FF, 1'b0, '0},
    '{24'h0000FF, 1'b0, '0},
    '{24'hFFFF00, 1'b0, '0},
    '{24'h00FFFF, 1'b0, '0},
    '{24'hFF0000, 1'b0, '0},
    '{24'h0000FF, 1'b0, '0},
    '{24'hFF00FF, 1'b0, '0},
    '{24'h00FF00, 1'b0, '0},
    '{24'h808080, 1'b0, '0},
    '{24'h010203, 1'b0, '0},
    '{24'hFE017F, 1'b0, '0},
    '{24'h000000, 1'b0, '0}
  };

  rgb_to_yuyv_filtered_chroma_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("tb_rgb_to_yuyv_filtered_chroma_core: done, errors");
    $finish;
  end

  function automatic logic [7:0] random_component();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  // Offer one pixel, then advance the converter state once it is taken
  task automatic send_pixel(input ryf_pixel_t pix, input bit typed, input ryf_yuyv_t typed_word);
    int r, g, b, width, sum_y, sum_cb, sum_cr;
    logic [7:0] y, cb, cr;
    ryf_yuyv_t word;
    int gap;
    if (!calm && $urandom_range(99) < 38) begin
      gap = $urandom_range(1, 3);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_word  <= pix;
    do @(posedge clk); while (in_stall);

    r = pix.red;
    g = pix.green;
    b = pix.blue;
    sum_y  = 66 * r + 129 * g + 25 * b + 128;
    sum_cb = -38 * r - 74 * g + 112 * b + 32896;
    sum_cr = 112 * r - 94 * g - 18 * b + 32896;
    y  = 8'((sum_y >> 8) + 16);
    cb = 8'(sum_cb >> 8);
    cr = 8'(sum_cr >> 8);

    // Hold the even pixel until its partner arrives
    if (col_count[0] == 1'b0) begin
      held_y  = y;
      held_cb = cb;
      held_cr = cr;
      col_count++;
      return;
    end

    // Width: drop bit 0, clamp to 2 .. max
    width = int'({width_reg[CFG_W-1:1], 1'b0});
    if (width < 2) width = 2;
    if (width > MAX_LINE_WIDTH_DEF) width = MAX_LINE_WIDTH_DEF;

    word.luma_even   = held_y;
    word.chroma_blue = 8'((left_cb + 2 * held_cb + cb + 2) >> 2);
    word.luma_odd    = y;
    word.chroma_red  = 8'((left_cr + 2 * held_cr + cr + 2) >> 2);
    word.line_end    = (col_count + 1 >= width);

    if (word.line_end) begin
      col_count = 0;
      left_cb   = 8'd128;
      left_cr   = 8'd128;
    end else begin
      col_count++;
      left_cb = cb;
      left_cr = cr;
    end
    expected_words.push_back(typed ? typed_word : word);
  endtask

  // Stop offering, wait for every owed word, then let the pipe empty
  task automatic settle(input int limit);
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_words.size() != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
    if (expected_words.size() != 0) begin
      $error("%0d expected words never arrived", expected_words.size());
      mismatches++;
      expected_words.delete();
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic write_line_width(input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    width_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random stalls, calm stretches, one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 38);
      end
    end
  end

  // Compare each accepted word against the oldest expectation
  always @(posedge clk) begin
    ryf_yuyv_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("unexpected output word %h", out_word);
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        check_field("luma_even", want.luma_even, out_word.luma_even);
        check_field("chroma_blue", want.chroma_blue, out_word.chroma_blue);
        check_field("luma_odd", want.luma_odd, out_word.luma_odd);
        check_field("chroma_red", want.chroma_red, out_word.chroma_red);
        check_field("line_end", want.line_end, out_word.line_end);
      end
    end
  end

  initial begin
    int widths[$];
    int total;
    int phase;
    int count;
    logic [CFG_W-1:0] w;
    ryf_pixel_t pix;

    widths = '{0, 1, 8191, 4096, 7, 2, 3, 6};
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;

    width_reg = CFG_W'(LINE_WIDTH_RST);
    col_count = 0;
    held_y    = 8'd0;
    held_cb   = 8'd128;
    held_cr   = 8'd128;
    left_cb   = 8'd128;
    left_cr   = 8'd128;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed pixels, left mid-line so the next width lands mid-line
    foreach (directed_rows[i])
      send_pixel(directed_rows[i].pix, directed_rows[i].typed, directed_rows[i].word);

    // Random phases, each under its own line width
    total = 20;
    phase = 0;
    while (total < 530) begin
      settle(2000);
      if (phase < widths.size())
        w = CFG_W'(widths[phase]);
      else if ($urandom_range(7) == 0)
        w = CFG_W'($urandom_range(8191));
      else
        w = CFG_W'($urandom_range(2, 40));
      write_line_width(w);

      count = $urandom_range(20, 60);
      calm  = (phase == 4);
      if (calm) count = 100;
      if (phase == 5) begin
        hold_request = 80;
        count = 60;
      end

      for (int i = 0; i < count; i++) begin
        pix.red   = random_component();
        pix.green = random_component();
        pix.blue  = random_component();
        send_pixel(pix, 1'b0, '0);
      end
      calm  = 1'b0;
      total += count;
      phase++;
    end

    settle(4000);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_rgb_to_yuyv_filtered_chroma_core: done, clean");
    end else begin
      $display("tb_rgb_to_yuyv_filtered_chroma_core: done, errors");
    end
    $finish;
  end

endmodule
